>>> sv/pvalu_pkg.sv
`timescale 1ns / 1ps
// pvalu_pkg: shared types and constants for the packed int8 vector alu
// no dependencies; imported by every module of the block
package pvalu_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int WORD_BYTES    = WORD_W / BYTE_W;
    localparam int OPCODE_W      = 3;
    localparam int SHAMT_W       = 3;
    localparam int DEFAULT_LANES = 4;
    localparam int IN_FIELDS_W   = 2 * WORD_W + SHAMT_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MUL  = 3'd0,
        OP_ACC  = 3'd1,
        OP_MAXR = 3'd2,
        OP_MINR = 3'd3,
        OP_LMAX = 3'd4,
        OP_SHR  = 3'd5
    } t_opcode;

    typedef struct packed {
        t_opcode              op;
        logic [SHAMT_W-1:0]   shamt;
    } t_lane_ctrl;

endpackage

>>> sv/pvalu_lane.sv
`timescale 1ns / 1ps
// pvalu_lane: one signed 8-bit lane for multiply, lane max and shift right
// depends on pvalu_pkg
module pvalu_lane (
    input  pvalu_pkg::t_lane_ctrl          i_ctrl,
    input  logic [pvalu_pkg::BYTE_W-1:0]   i_a,
    input  logic [pvalu_pkg::BYTE_W-1:0]   i_b,
    output logic [pvalu_pkg::BYTE_W-1:0]   o_y
);
    import pvalu_pkg::*;

    logic signed [BYTE_W-1:0]   w_a;
    logic signed [BYTE_W-1:0]   w_b;
    logic [BYTE_W-1:0]          w_prod;

    assign w_a    = $signed(i_a);
    assign w_b    = $signed(i_b);
    // low byte of the product is the same for signed and unsigned operands
    assign w_prod = i_a * i_b;

    always_comb begin
        case (i_ctrl.op)
            OP_MUL:  o_y = w_prod[BYTE_W-1:0];
            OP_LMAX: o_y = (w_a > w_b) ? i_a : i_b;
            OP_SHR:  o_y = w_a >>> i_ctrl.shamt;
            default: o_y = '0;
        endcase
    end

endmodule

>>> sv/pvalu_reduce.sv
`timescale 1ns / 1ps
// pvalu_reduce: sum, max and min over the lanes of one vector, sign-extended
// depends on pvalu_pkg
module pvalu_reduce #(
    parameter int LANES = pvalu_pkg::DEFAULT_LANES
) (
    input  pvalu_pkg::t_opcode             i_op,
    input  logic [pvalu_pkg::WORD_W-1:0]   i_vector,
    output logic [pvalu_pkg::WORD_W-1:0]   o_scalar
);
    import pvalu_pkg::*;

    localparam int WORD_LANES = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;
    localparam bit HAS_PAD    = (LANES > WORD_BYTES);
    localparam int SUM_W      = BYTE_W + 3;

    logic signed [BYTE_W-1:0]   w_v;
    logic signed [BYTE_W-1:0]   w_max;
    logic signed [BYTE_W-1:0]   w_min;
    logic signed [SUM_W-1:0]    w_sum;

    always_comb begin
        w_max = $signed(i_vector[BYTE_W-1:0]);
        w_min = $signed(i_vector[BYTE_W-1:0]);
        w_sum = '0;
        w_v   = '0;
        for (int p = 0; p < WORD_LANES; p++) begin
            w_v   = $signed(i_vector[p*BYTE_W +: BYTE_W]);
            w_sum = w_sum + $signed({{(SUM_W-BYTE_W){w_v[BYTE_W-1]}}, w_v});
            if (w_v > w_max) begin
                w_max = w_v;
            end
            if (w_v < w_min) begin
                w_min = w_v;
            end
        end
        // lanes outside the word count as zero
        if (HAS_PAD) begin
            if (w_max[BYTE_W-1]) begin
                w_max = '0;
            end
            if (!w_min[BYTE_W-1]) begin
                w_min = '0;
            end
        end
        case (i_op)
            OP_ACC:  o_scalar = {{(WORD_W-SUM_W){w_sum[SUM_W-1]}}, w_sum};
            OP_MAXR: o_scalar = {{(WORD_W-BYTE_W){w_max[BYTE_W-1]}}, w_max};
            OP_MINR: o_scalar = {{(WORD_W-BYTE_W){w_min[BYTE_W-1]}}, w_min};
            default: o_scalar = '0;
        endcase
    end

endmodule

>>> sv/packed_int8_vector_alu.sv
`timescale 1ns / 1ps
// packed_int8_vector_alu: packed signed 8-bit simd alu, top level
// depends on pvalu_pkg, pvalu_lane, pvalu_reduce
//
// channel   dir  tdata (low bit up)                         tuser
// s_axis    in   vector_a[31:0] vector_b[63:32]             opcode[2:0]
//                shift_amount[66:64] zero[71:67]
// m_axis    out  result[31:0]                               -
//
// an input transaction passes through the input register, then the result register
// one transaction per cycle sustained while m_axis accepts; the lane and reduce logic sits between the two
// synchronous active-low reset clears both valid flags
// a stall on m_axis holds the result register, then backs up into the input register
module packed_int8_vector_alu #(
    parameter int LANES = pvalu_pkg::DEFAULT_LANES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // vector_a, vector_b, shift_amount, zero pad
    input  logic [pvalu_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // opcode
    input  logic [pvalu_pkg::OPCODE_W-1:0]        i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // result
    output logic [pvalu_pkg::WORD_W-1:0]          o_m_axis_tdata
);
    import pvalu_pkg::*;

    logic                   r_s1_valid;
    logic                   n_s1_valid;
    t_opcode                r_s1_op;
    logic [WORD_W-1:0]      r_s1_a;
    logic [WORD_W-1:0]      r_s1_b;
    logic [SHAMT_W-1:0]     r_s1_sh;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [WORD_W-1:0]      r_out_data;
    logic [WORD_W-1:0]      n_result;
    logic                   w_s1_ready;
    logic                   w_in_fire;
    logic                   w_s1_fire;
    t_lane_ctrl             w_ctrl;
    logic [WORD_W-1:0]      w_packed;
    logic [WORD_W-1:0]      w_scalar;

    assign w_s1_ready      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || w_s1_ready;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_s1_fire       = r_s1_valid && w_s1_ready;
    assign n_s1_valid      = w_in_fire || (r_s1_valid && !w_s1_ready);
    assign n_out_valid     = w_s1_fire || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_op <= t_opcode'(i_s_axis_tuser);
            r_s1_a  <= i_s_axis_tdata[WORD_W-1:0];
            r_s1_b  <= i_s_axis_tdata[2*WORD_W-1:WORD_W];
            r_s1_sh <= i_s_axis_tdata[2*WORD_W +: SHAMT_W];
        end
        if (w_s1_fire) begin
            r_out_data <= n_result;
        end
    end

    assign w_ctrl.op    = r_s1_op;
    assign w_ctrl.shamt = r_s1_sh;

    // byte position p holds lane p
    for (genvar p = 0; p < WORD_BYTES; p++) begin : g_lane
        if (p < LANES) begin : g_used
            pvalu_lane u_lane (
                .i_ctrl (w_ctrl),
                .i_a    (r_s1_a[p*BYTE_W +: BYTE_W]),
                .i_b    (r_s1_b[p*BYTE_W +: BYTE_W]),
                .o_y    (w_packed[p*BYTE_W +: BYTE_W])
            );
        end else begin : g_unused
            assign w_packed[p*BYTE_W +: BYTE_W] = '0;
        end
    end

    pvalu_reduce #(
        .LANES (LANES)
    ) u_reduce (
        .i_op     (r_s1_op),
        .i_vector (r_s1_a),
        .o_scalar (w_scalar)
    );

    always_comb begin
        case (r_s1_op)
            OP_MUL, OP_LMAX, OP_SHR: n_result = w_packed;
            OP_ACC, OP_MAXR, OP_MINR: n_result = w_scalar;
            default: n_result = '0;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_s1_valid)
        else $error("accepted transaction did not reach the input register");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire |=> o_m_axis_tvalid)
        else $error("result register did not load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_ready |=> r_s1_valid && $stable(r_s1_a) && $stable(r_s1_op))
        else $error("input register lost a stalled transaction");

    a_minmax_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1_op == OP_MAXR || r_s1_op == OP_MINR)
        |-> (n_result[WORD_W-1:BYTE_W-1] == '0 || n_result[WORD_W-1:BYTE_W-1] == '1))
        else $error("reduction result is not sign extended");

    a_bad_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_op != OP_MUL && r_s1_op != OP_ACC && r_s1_op != OP_MAXR
        && r_s1_op != OP_MINR && r_s1_op != OP_LMAX && r_s1_op != OP_SHR
        |-> n_result == '0)
        else $error("unused opcode gave a nonzero result");
`endif

endmodule
